@@ hdl/pcmsg_pkg.sv @@
// shared types, constants and command codes of the pcm sound generator
`timescale 1ns / 1ps
package pcmsg_pkg;
   localparam int ChannelsDefault = 8;
   localparam int WaveAddrBitsDefault = 16;
   localparam int PosBits = 27;

   typedef enum logic [2:0] {
      CMD_REG_WRITE  = 3'd0,
      CMD_REG_READ   = 3'd1,
      CMD_WAVE_WRITE = 3'd2,
      CMD_WAVE_READ  = 3'd3,
      CMD_TICK       = 3'd4
   } cmd_type;

   localparam logic [11:0] REG_ENVELOPE = 12'd0;
   localparam logic [11:0] REG_PAN      = 12'd1;
   localparam logic [11:0] REG_STEP_LO  = 12'd2;
   localparam logic [11:0] REG_STEP_HI  = 12'd3;
   localparam logic [11:0] REG_LOOP_LO  = 12'd4;
   localparam logic [11:0] REG_LOOP_HI  = 12'd5;
   localparam logic [11:0] REG_PAGE     = 12'd6;
   localparam logic [11:0] REG_CONTROL  = 12'd7;
   localparam logic [11:0] REG_CHAN_OFF = 12'd8;

   localparam logic [7:0] END_MARK = 8'hFF;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;      // latch request, clear accumulators
      logic do_reg;     // register write / read handling
      logic do_wave_wr; // write wave byte
      logic wave_rd;    // issue memory read at window address
      logic clear_pass; // write END_MARK at clear counter
      logic ch_rd;      // issue memory read at channel position
      logic loop_rd;    // issue memory read at loop address
      logic ch_eval;    // evaluate fetched byte of current channel
      logic loop_eval;  // evaluate byte fetched after loop jump
      logic mul;        // register pan * envelope products
      logic acc;        // accumulate current channel
      logic next_ch;    // advance channel index
      logic cap_rd;     // capture read byte into result
   } ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic last_ch;
      logic ch_active;
      logic is_end;
      logic chip_on;
   } sts_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [11:0] offset;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
   } rsp_type;
endpackage

@@ hdl/pcmsg_if.sv @@
// valid / ready channel interface carrying one payload
`timescale 1ns / 1ps
interface pcmsg_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/pcmsg_ctrl.sv @@
// controller state machine sequencing requests over the datapath
`timescale 1ns / 1ps
module pcmsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_cmd,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pcmsg_pkg::sts_type   sts,
   output pcmsg_pkg::ctl_type   ctl
);
   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_DECODE = 10'b0000000100,
      ST_RDWAIT = 10'b0000001000,
      ST_CHRD   = 10'b0000010000,
      ST_CHEVAL = 10'b0000100000,
      ST_LPEVAL = 10'b0001000000,
      ST_MUL    = 10'b0010000000,
      ST_ACC    = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_pass = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.start = 1'b1;
               cmd_in = req_cmd;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               pcmsg_pkg::CMD_REG_WRITE, pcmsg_pkg::CMD_REG_READ: begin
                  ctl.do_reg = 1'b1;
                  state_in = ST_OUT;
               end
               pcmsg_pkg::CMD_WAVE_WRITE: begin
                  ctl.do_wave_wr = 1'b1;
                  state_in = ST_OUT;
               end
               pcmsg_pkg::CMD_WAVE_READ: begin
                  ctl.wave_rd = 1'b1;
                  state_in = ST_RDWAIT;
               end
               pcmsg_pkg::CMD_TICK: begin
                  state_in = sts.chip_on ? ST_CHRD : ST_OUT;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_RDWAIT: begin
            ctl.cap_rd = 1'b1;
            state_in = ST_OUT;
         end
         ST_CHRD: begin
            if (sts.ch_active) begin
               ctl.ch_rd = 1'b1;
               ctl.mul = 1'b1;
               state_in = ST_CHEVAL;
            end else if (sts.last_ch) begin
               state_in = ST_OUT;
            end else begin
               ctl.next_ch = 1'b1;
            end
         end
         ST_CHEVAL: begin
            ctl.ch_eval = 1'b1;
            if (sts.is_end) begin
               ctl.loop_rd = 1'b1;
               state_in = ST_LPEVAL;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_LPEVAL: begin
            ctl.loop_eval = 1'b1;
            if (sts.is_end) begin
               if (sts.last_ch) state_in = ST_OUT;
               else begin
                  ctl.next_ch = 1'b1;
                  state_in = ST_CHRD;
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctl.acc = 1'b1;
            if (sts.last_ch) state_in = ST_OUT;
            else begin
               ctl.next_ch = 1'b1;
               state_in = ST_CHRD;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cmd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ hdl/pcmsg_dp.sv @@
// datapath: channel registers, wave memory, multiply and saturating mix
`timescale 1ns / 1ps
module pcmsg_dp #(
   parameter int CHANNELS = pcmsg_pkg::ChannelsDefault,
   parameter int WAVE_ADDR_BITS = pcmsg_pkg::WaveAddrBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcmsg_pkg::ctl_type   ctl,
   output pcmsg_pkg::sts_type   sts,
   input  pcmsg_pkg::req_type   req,
   output pcmsg_pkg::rsp_type   rsp
);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = WAVE_ADDR_BITS;
   localparam int PB = pcmsg_pkg::PosBits;

   logic [7:0]    env_ff [CHANNELS];
   logic [7:0]    pan_ff [CHANNELS];
   logic [15:0]   step_ff [CHANNELS];
   logic [15:0]   loop_ff [CHANNELS];
   logic [7:0]    page_ff [CHANNELS];
   logic [PB-1:0] pos_ff [CHANNELS];
   logic [CHANNELS-1:0] active_ff;
   logic          chip_on_ff;
   logic [2:0]    sel_ff;
   logic [3:0]    bank_ff;

   logic [7:0]    mem [2**AW];
   logic [7:0]    mem_q_ff;
   logic [AW:0]   clr_ff;

   pcmsg_pkg::req_type req_ff;
   logic [CW-1:0] ch_ff;
   logic [7:0]    smp_ff;
   logic [11:0]   lv_ff, rv_ff;
   logic signed [19:0] dl_ff, dr_ff;
   logic signed [15:0] l_ff, r_ff;
   logic [7:0]    rd_ff;

   logic [AW-1:0] win_addr, pos_addr, loop_addr, rd_addr;
   logic [15:0]   win_full;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [2:0]    rch;
   logic [2:0]    wch;
   logic signed [17:0] l_sum, r_sum;

   assign win_full = {bank_ff, req_ff.offset};
   assign win_addr = win_full[AW-1:0];
   assign pos_addr = pos_ff[ch_ff][11 +: AW];
   assign loop_addr = loop_ff[ch_ff][AW-1:0];
   assign rd_addr = ctl.loop_rd ? loop_addr : (ctl.ch_rd ? pos_addr : win_addr);

   always_comb begin
      mem_we = 1'b0;
      wr_addr = win_addr;
      wr_data = req_ff.data;
      if (ctl.clear_pass) begin
         mem_we = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = pcmsg_pkg::END_MARK;
      end else if (ctl.do_wave_wr) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (ctl.clear_pass && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
   end

   assign sts.clear_done = (clr_ff[AW-1:0] == {AW{1'b1}});
   assign sts.last_ch = (ch_ff == CW'(CHANNELS - 1));
   assign sts.ch_active = active_ff[ch_ff];
   assign sts.is_end = (mem_q_ff == pcmsg_pkg::END_MARK);
   assign sts.chip_on = chip_on_ff;

   assign rch = 3'(req_ff.offset[3:1]);
   assign wch = sel_ff;

   always_comb begin
      l_sum = 18'(l_ff) + 18'(smp_ff[7] ? dl_ff : -dl_ff);
      r_sum = 18'(r_ff) + 18'(smp_ff[7] ? dr_ff : -dr_ff);
   end

   function automatic logic signed [15:0] sat(input logic signed [17:0] v);
      if (v > 18'sd32767) return 16'sh7FFF;
      if (v < -18'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         req_ff <= req;
         ch_ff <= '0;
         l_ff <= '0;
         r_ff <= '0;
         rd_ff <= '0;
      end
      if (ctl.next_ch) ch_ff <= ch_ff + 1'b1;
      if (ctl.mul) begin
         lv_ff <= 12'(pan_ff[ch_ff][3:0]) * 12'(env_ff[ch_ff]);
         rv_ff <= 12'(pan_ff[ch_ff][7:4]) * 12'(env_ff[ch_ff]);
      end
      if ((ctl.ch_eval && !sts.is_end) || (ctl.loop_eval && !sts.is_end)) begin
         smp_ff <= mem_q_ff;
         dl_ff <= 20'(({12'd0, mem_q_ff[6:0]} * {7'd0, lv_ff}) >> 5);
         dr_ff <= 20'(({12'd0, mem_q_ff[6:0]} * {7'd0, rv_ff}) >> 5);
      end
      if (ctl.acc) begin
         l_ff <= sat(l_sum);
         r_ff <= sat(r_sum);
      end
      if (ctl.cap_rd) rd_ff <= mem_q_ff;
      if (ctl.do_reg && req_ff.cmd == pcmsg_pkg::CMD_REG_READ) begin
         if (32'(rch) < CHANNELS)
            rd_ff <= req_ff.offset[0] ? pos_ff[CW'(rch)][26:19] : pos_ff[CW'(rch)][18:11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            env_ff[i] <= '0; pan_ff[i] <= '0; step_ff[i] <= '0;
            loop_ff[i] <= '0; page_ff[i] <= '0; pos_ff[i] <= '0;
         end
         active_ff <= '0;
         chip_on_ff <= 1'b0;
         sel_ff <= '0;
         bank_ff <= '0;
      end else begin
         if (ctl.do_reg && req_ff.cmd == pcmsg_pkg::CMD_REG_WRITE) begin
            unique case (req_ff.offset)
               pcmsg_pkg::REG_CONTROL: begin
                  chip_on_ff <= req_ff.data[7];
                  if (req_ff.data[6]) sel_ff <= req_ff.data[2:0];
                  else bank_ff <= req_ff.data[3:0];
               end
               pcmsg_pkg::REG_CHAN_OFF: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     active_ff[i] <= !req_ff.data[i];
                     if (req_ff.data[i]) pos_ff[i] <= {page_ff[i], 19'd0};
                  end
               end
               pcmsg_pkg::REG_ENVELOPE, pcmsg_pkg::REG_PAN, pcmsg_pkg::REG_STEP_LO,
               pcmsg_pkg::REG_STEP_HI, pcmsg_pkg::REG_LOOP_LO, pcmsg_pkg::REG_LOOP_HI,
               pcmsg_pkg::REG_PAGE: begin
                  if (32'(wch) < CHANNELS) begin
                     unique case (req_ff.offset)
                        pcmsg_pkg::REG_ENVELOPE: env_ff[CW'(wch)] <= req_ff.data;
                        pcmsg_pkg::REG_PAN: pan_ff[CW'(wch)] <= req_ff.data;
                        pcmsg_pkg::REG_STEP_LO: step_ff[CW'(wch)][7:0] <= req_ff.data;
                        pcmsg_pkg::REG_STEP_HI: step_ff[CW'(wch)][15:8] <= req_ff.data;
                        pcmsg_pkg::REG_LOOP_LO: loop_ff[CW'(wch)][7:0] <= req_ff.data;
                        pcmsg_pkg::REG_LOOP_HI: loop_ff[CW'(wch)][15:8] <= req_ff.data;
                        default: begin
                           page_ff[CW'(wch)] <= req_ff.data;
                           if (!active_ff[CW'(wch)])
                              pos_ff[CW'(wch)] <= {req_ff.data, 19'd0};
                        end
                     endcase
                  end
               end
               default: ;
            endcase
         end
         if (ctl.ch_eval && sts.is_end) pos_ff[ch_ff] <= {loop_ff[ch_ff], 11'd0};
         if (ctl.acc) pos_ff[ch_ff] <= pos_ff[ch_ff] + PB'(step_ff[ch_ff]);
      end
   end

   assign rsp.read_data = rd_ff;
   assign rsp.left_sample = l_ff;
   assign rsp.right_sample = r_ff;
endmodule

@@ hdl/eight_channel_pcm_sound_generator.sv @@
// top level of the eight-channel pcm sound generator
//
// one request channel (req) carries cmd, offset and data; one response
// channel (rsp) returns read_data, left_sample and right_sample, one
// response per request, valid/ready handshakes on both.
// commands: register write, register read, wave write, wave read, tick.
// a tick visits each channel in turn through one wave memory read port.
// an active channel reads the byte at its position; on an end mark it
// jumps to its loop start and reads the loop byte, and is skipped if
// that is an end mark as well; otherwise the byte is scaled and mixed
// in. inactive channels are skipped.
// one request is in flight at a time; a new request is taken once the
// previous response has been handed off.
// after reset the wave memory is filled with end marks by a clearing
// pass during which no request is taken.
// a stalled receiver holds the response and blocks new requests.
`timescale 1ns / 1ps
module eight_channel_pcm_sound_generator #(
   parameter int CHANNELS = pcmsg_pkg::ChannelsDefault,
   parameter int WAVE_ADDR_BITS = pcmsg_pkg::WaveAddrBitsDefault
) (
   input logic clock,
   input logic reset,
   pcmsg_if.sink   req,
   pcmsg_if.source rsp
);
   pcmsg_pkg::ctl_type ctl;
   pcmsg_pkg::sts_type sts;
   pcmsg_pkg::req_type req_p;
   pcmsg_pkg::rsp_type rsp_p;

   assign req_p = req.payload;
   assign rsp.payload = rsp_p;

   pcmsg_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_cmd(req_p.cmd), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .ctl
   );

   pcmsg_dp #(.CHANNELS(CHANNELS), .WAVE_ADDR_BITS(WAVE_ADDR_BITS)) u_dp (
      .clock, .reset, .ctl, .sts, .req(req_p), .rsp(rsp_p)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken with response pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid) else $error("response too early");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.ch_rd, ctl.loop_rd, ctl.wave_rd})) else $error("read port conflict");
endmodule
